### hdl/gec_pkg.sv
// gec_pkg: shared constants and pipeline stage type for the gamma encoder
// no dependencies; imported by the stage modules and the top level
`default_nettype none

package gec_pkg;

   localparam int SAMPLE_W        = 24;
   localparam int GAMMA_W         = 16;
   localparam int BYTE_W          = 8;
   localparam int Q_W             = 32;
   localparam int REM_W           = Q_W + 2;
   localparam int FRAC_BITS       = 12;
   localparam int INT_BITS        = GAMMA_W - FRAC_BITS;
   localparam int INT_STAGES      = (1 << INT_BITS) - 1;
   localparam int SQRT_STEPS      = Q_W;
   localparam int ROUND_W         = Q_W + BYTE_W;

   localparam logic [GAMMA_W-1:0] INV_GAMMA_RESET = 16'd1862;
   localparam logic [BYTE_W-1:0]  BYTE_MAX        = 8'd255;

   typedef struct packed {
      logic             valid;
      logic             frozen;
      logic             acc_one;
      logic [Q_W-1:0]   acc;
      logic [Q_W-1:0]   rad;
      logic [REM_W-1:0] rem;
      logic [Q_W-1:0]   root;
   } pipe_type;

endpackage

`default_nettype wire

### hdl/gec_ifs.sv
// gec_req_if / gec_rsp_if: valid-ready channels for samples and pixel codes
// depends on gec_pkg for field widths
`default_nettype none

interface gec_req_if;
   logic                          valid;
   logic                          ready;
   logic [gec_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface gec_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gec_pkg::BYTE_W-1:0]  pixel_byte;

   modport source (output valid, output pixel_byte, input ready);
   modport sink (input valid, input pixel_byte, output ready);
endinterface

`default_nettype wire

### hdl/gec_mul_stage.sv
// gec_mul_stage: one registered, conditional Q0.32 multiply of the running power
// depends on gec_pkg for the stage type
`default_nettype none

module gec_mul_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              do_mul,
   input  wire logic [31:0]       operand,
   input  wire logic [31:0]       next_rad,
   input  wire gec_pkg::pipe_type up,
   output gec_pkg::pipe_type      dn
);
   import gec_pkg::*;

   pipe_type          stage_ff;
   pipe_type          stage_in;
   logic [2*Q_W-1:0]  product;

   assign product = up.acc * operand;

   always_comb begin
      stage_in      = up;
      stage_in.rad  = next_rad;
      stage_in.rem  = '0;
      stage_in.root = '0;
      if (do_mul && !up.frozen) begin
         stage_in.acc_one = 1'b0;
         // one times operand is the operand itself
         stage_in.acc = up.acc_one ? operand : product[2*Q_W-1:Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign dn = stage_ff;

endmodule

`default_nettype wire

### hdl/gec_sqrt_step.sv
// gec_sqrt_step: one root bit of the integer square root of rad shifted by 32
// depends on gec_pkg for the stage type
`default_nettype none

module gec_sqrt_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire gec_pkg::pipe_type up,
   output gec_pkg::pipe_type      dn
);
   import gec_pkg::*;

   pipe_type          stage_ff;
   pipe_type          stage_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   assign rem_sh = {up.rem[Q_W-1:0], up.rad[Q_W-1:Q_W-2]};
   assign trial  = {up.root, 2'b01};

   always_comb begin
      stage_in     = up;
      stage_in.rad = {up.rad[Q_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         stage_in.rem  = rem_sh - trial;
         stage_in.root = {up.root[Q_W-2:0], 1'b1};
      end else begin
         stage_in.rem  = rem_sh;
         stage_in.root = {up.root[Q_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign dn = stage_ff;

endmodule

`default_nettype wire

### hdl/gamma_encode_to_byte_unit.sv
// gamma_encode_to_byte_unit: sample^(inv_gamma) scaled to an 8-bit code
// pipeline of an entry register, 15 integer-power multiplies, twelve
// rounds of a 32-step square root plus one multiply, and the output register
// throughput one transfer per cycle; the whole pipe holds while the output waits
// reset (synchronous) empties the pipe and sets inv_gamma to 1862 (about 1/2.2)
// depends on gec_pkg, gec_ifs, gec_mul_stage, gec_sqrt_step
`default_nettype none

module gamma_encode_to_byte_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   gec_req_if.sink                             req_ch,
   gec_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_wr_en,
   input  wire logic [gec_pkg::GAMMA_W-1:0]    csr_wr_data
);
   import gec_pkg::*;

   logic [GAMMA_W-1:0]  inv_gamma_ff;
   logic                advance;
   pipe_type            entry_ff;
   pipe_type            entry_in;
   pipe_type            int_q [0:INT_STAGES];
   pipe_type            frac_q [0:FRAC_BITS];
   pipe_type            sq_q [0:FRAC_BITS-1][0:SQRT_STEPS];
   pipe_type            last;
   logic [ROUND_W-1:0]  scaled;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic [BYTE_W-1:0]   rsp_byte_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_gamma_ff <= INV_GAMMA_RESET;
      end else if (csr_wr_en) begin
         inv_gamma_ff <= csr_wr_data;
      end
   end

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance && !reset;

   // entry: zero and at-or-above-one samples are frozen at their final value
   always_comb begin
      entry_in         = '0;
      entry_in.valid   = req_ch.valid;
      entry_in.acc_one = (req_ch.sample != '0);
      entry_in.frozen  = (req_ch.sample == '0) || (req_ch.sample[SAMPLE_W-1:16] != '0);
      entry_in.rad     = {req_ch.sample[15:0], 16'h0000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign int_q[0] = entry_ff;

   // integer part of the exponent
   for (genvar k = 0; k < INT_STAGES; k++) begin : g_int
      gec_mul_stage u_mul (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .do_mul   (inv_gamma_ff[GAMMA_W-1:FRAC_BITS] > INT_BITS'(k)),
         .operand  (int_q[k].rad),
         .next_rad (int_q[k].rad),
         .up       (int_q[k]),
         .dn       (int_q[k+1])
      );
   end

   assign frac_q[0] = int_q[INT_STAGES];

   // fraction bits: successive square roots of the base
   for (genvar j = 0; j < FRAC_BITS; j++) begin : g_frac
      assign sq_q[j][0] = frac_q[j];

      for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
         gec_sqrt_step u_step (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .up      (sq_q[j][s]),
            .dn      (sq_q[j][s+1])
         );
      end

      gec_mul_stage u_mul (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .do_mul   (inv_gamma_ff[FRAC_BITS-1-j]),
         .operand  (sq_q[j][SQRT_STEPS].root),
         .next_rad (sq_q[j][SQRT_STEPS].root),
         .up       (sq_q[j][SQRT_STEPS]),
         .dn       (frac_q[j+1])
      );
   end

   assign last = frac_q[FRAC_BITS];

   // 255 * acc + one half, rounded to the top byte
   assign scaled = {last.acc, 8'h00} - ROUND_W'(last.acc) + (ROUND_W'(1) << (Q_W - 1));

   always_comb begin
      rsp_valid_in = last.valid;
      rsp_byte_in  = last.acc_one ? BYTE_MAX : scaled[ROUND_W-1:Q_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff <= rsp_byte_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pixel_byte = rsp_byte_ff;

endmodule

`default_nettype wire
